[sv/b64sc_pkg.sv]
// ----------------------------------------------------------------------------
// b64sc_pkg
// Shared constants, job type and alphabet functions of the base64 codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

  localparam int B64SC_QUEUE_DEPTH = 2;
  localparam int MAX_RESULTS       = 4;

  localparam logic [7:0] PAD_CHAR  = 8'h3D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;

  // results of one input item, emitted one per cycle by the back end while out_ch is ready
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] chars;
    logic [2:0]                  n;
    logic                        dv;
    logic                        eom;
  } job_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = CH_UPPER_A + {2'b00, v};
    end else if (v < 6'd52) begin
      c = CH_LOWER_A + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = CH_DIGIT_0 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = CH_PLUS;
    end else begin
      c = CH_SLASH;
    end
    return c;
  endfunction

  // {in alphabet, six-bit value}
  function automatic logic [6:0] b64_sextet(input logic [7:0] ch);
    logic [7:0] d;
    logic [6:0] r;
    d = 8'd0;
    r = 7'd0;
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      d = ch - CH_UPPER_A;
      r = {1'b1, d[5:0]};
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      d = ch - CH_LOWER_A + 8'd26;
      r = {1'b1, d[5:0]};
    end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
      d = ch - CH_DIGIT_0 + 8'd52;
      r = {1'b1, d[5:0]};
    end else if (ch == CH_PLUS) begin
      r = {1'b1, 6'd62};
    end else if (ch == CH_SLASH) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

[sv/b64sc_if.sv]
// ----------------------------------------------------------------------------
// b64sc_if
// Valid/ready channels of the base64 codec: input items and result items.
// ----------------------------------------------------------------------------
interface b64sc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last;

  modport source (output valid, output in_byte, output last, input ready);
  modport sink   (input valid, input in_byte, input last, output ready);
endinterface

interface b64sc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       data_valid;
  logic       end_of_message;

  modport source (output valid, output out_byte, output data_valid,
                  output end_of_message, input ready);
  modport sink   (input valid, input out_byte, input data_valid,
                  input end_of_message, output ready);
endinterface

[sv/base64_stream_codec_top.sv]
// ----------------------------------------------------------------------------
// base64_stream_codec_top
// Streaming base64 encoder and decoder with a decoupled front and back end.
//
//   channel   direction  handshake    payload
//   in_ch     in         valid/ready  in_byte[7:0], last
//   out_ch    out        valid/ready  out_byte[7:0], data_valid, end_of_message
//   cfg       in         cfg_wr_en    cfg_wr_data[0] = decode_mode
//
// one input item per cycle enters while the job queue has room
// the back end emits one result item per cycle while out_ch is ready: an encoded byte gives 1 or 2
// result items (up to 4 on the last byte), a decoded character 1 item or none
// the front end takes new bytes while the back end still emits results of earlier ones
// synchronous reset clears control state but not the queue memory; a cfg write clears message state
// stalls on out_ch fill the queue and then hold in_ch.ready low
// ----------------------------------------------------------------------------
module base64_stream_codec_top
  import b64sc_pkg::*;
#(
  parameter int QUEUE_DEPTH = B64SC_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  b64sc_in_if.sink    in_ch,
  b64sc_out_if.source out_ch,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_wr_data
);

  logic push, pop, full, q_valid;
  job_t wr_job, head;

  b64sc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (full),
    .push        (push),
    .job         (wr_job)
  );

  b64sc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_job  (wr_job),
    .pop     (pop),
    .full    (full),
    .q_valid (q_valid),
    .head    (head)
  );

  b64sc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

[sv/b64sc_front.sv]
// ----------------------------------------------------------------------------
// b64sc_front
// Accepts input items, updates residue state and builds at most one job per item.
// ----------------------------------------------------------------------------
module b64sc_front
  import b64sc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  b64sc_in_if.sink    in_ch,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_wr_data,
  input  logic        q_full,
  output logic        push,
  output job_t        job
);

  logic       mode_r;
  logic [5:0] rb_r, rb_nxt;
  logic [2:0] rc_r, rc_nxt;
  logic       halted_r, halted_nxt;
  logic [1:0] cm_r, cm_nxt;

  logic       acc_in;
  logic [7:0] b;
  logic       lst;

  logic [5:0] s0, s1, fv;
  logic [1:0] nd;
  logic       fl;
  logic [2:0] ndata, total, tsum;
  logic [1:0] cm_a, pads;
  logic [6:0] sx;
  logic       got;
  logic [7:0] dbyte;

  assign in_ch.ready = !q_full;
  assign acc_in      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign lst         = in_ch.last;

  always_comb begin
    rb_nxt     = rb_r;
    rc_nxt     = rc_r;
    halted_nxt = halted_r;
    cm_nxt     = cm_r;
    s0 = 6'd0; s1 = 6'd0; fv = 6'd0; nd = 2'd1; fl = 1'b0;
    ndata = 3'd0; total = 3'd0; tsum = 3'd0; cm_a = 2'd0; pads = 2'd0;
    sx = b64_sextet(b);
    got = 1'b0;
    dbyte = 8'd0;
    job = '0;
    push = 1'b0;
    if (!mode_r) begin
      case (rc_r)
        3'd2: begin
          s0 = {rb_r[1:0], b[7:4]}; nd = 2'd1;
          rb_nxt = {2'b00, b[3:0]}; rc_nxt = 3'd4;
        end
        3'd4: begin
          s0 = {rb_r[3:0], b[7:6]}; s1 = b[5:0]; nd = 2'd2;
          rb_nxt = 6'd0; rc_nxt = 3'd0;
        end
        default: begin
          s0 = b[7:2]; nd = 2'd1;
          rb_nxt = {4'b0000, b[1:0]}; rc_nxt = 3'd2;
        end
      endcase
      fl    = lst && (rc_nxt != 3'd0);
      fv    = (rc_nxt == 3'd4) ? {rb_nxt[3:0], 2'b00} : {rb_nxt[1:0], 4'b0000};
      ndata = {1'b0, nd} + {2'b00, fl};
      cm_a  = cm_r + ndata[1:0];
      pads  = lst ? (2'd0 - cm_a) : 2'd0;
      tsum  = ndata + {1'b0, pads};
      total = (tsum > 3'd4) ? 3'd4 : tsum;
      cm_nxt = cm_r + total[1:0];
      for (int k = 0; k < MAX_RESULTS; k++) begin
        if (k < int'(nd)) begin
          job.chars[k] = b64_char((k == 0) ? s0 : s1);
        end else if (k == int'(nd) && fl) begin
          job.chars[k] = b64_char(fv);
        end else begin
          job.chars[k] = PAD_CHAR;
        end
      end
      job.n   = total;
      job.dv  = 1'b1;
      job.eom = lst;
      push    = acc_in;
    end else begin
      if (!halted_r) begin
        if (!sx[6]) begin
          halted_nxt = 1'b1;
        end else begin
          case (rc_r)
            3'd6: begin
              got = 1'b1; dbyte = {rb_r, sx[5:4]};
              rb_nxt = {2'b00, sx[3:0]}; rc_nxt = 3'd4;
            end
            3'd4: begin
              got = 1'b1; dbyte = {rb_r[3:0], sx[5:2]};
              rb_nxt = {4'b0000, sx[1:0]}; rc_nxt = 3'd2;
            end
            3'd2: begin
              got = 1'b1; dbyte = {rb_r[1:0], sx[5:0]};
              rb_nxt = 6'd0; rc_nxt = 3'd0;
            end
            default: begin
              rb_nxt = sx[5:0]; rc_nxt = 3'd6;
            end
          endcase
        end
      end
      job.chars[0] = dbyte;
      job.n        = 3'd1;
      job.dv       = got;
      job.eom      = lst;
      push         = acc_in && (lst || got);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      rb_r     <= 6'd0;
      rc_r     <= 3'd0;
      halted_r <= 1'b0;
      cm_r     <= 2'd0;
    end else if (cfg_wr_en) begin
      mode_r   <= cfg_wr_data[0];
      rb_r     <= 6'd0;
      rc_r     <= 3'd0;
      halted_r <= 1'b0;
      cm_r     <= 2'd0;
    end else if (acc_in) begin
      if (lst) begin
        rb_r     <= 6'd0;
        rc_r     <= 3'd0;
        halted_r <= 1'b0;
        cm_r     <= 2'd0;
      end else begin
        rb_r     <= rb_nxt;
        rc_r     <= rc_nxt;
        halted_r <= halted_nxt;
        cm_r     <= cm_nxt;
      end
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_in && lst) |=> (rc_r == 3'd0 && cm_r == 2'd0 && !halted_r))
    else $error("message state not cleared after last item");

  a_enc_job_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !mode_r) |-> (job.n != 3'd0))
    else $error("encode job without results");

endmodule

[sv/b64sc_queue.sv]
// ----------------------------------------------------------------------------
// b64sc_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module b64sc_queue
  import b64sc_pkg::*;
#(
  parameter int DEPTH = B64SC_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_job,
  input  logic pop,
  output logic full,
  output logic q_valid,
  output job_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> !pop)
    else $error("pop from empty queue");

endmodule

[sv/b64sc_back.sv]
// ----------------------------------------------------------------------------
// b64sc_back
// Walks the head job and emits its result items, one per cycle while out_ch is ready.
// ----------------------------------------------------------------------------
module b64sc_back
  import b64sc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  job_t        head,
  output logic        pop,
  b64sc_out_if.source out_ch
);

  logic [1:0] idx_r;
  logic       last_slot;
  logic       fire;

  assign last_slot = ({1'b0, idx_r} == (head.n - 3'd1));
  assign fire      = out_ch.valid && out_ch.ready;
  assign pop       = fire && last_slot;

  assign out_ch.valid          = q_valid;
  assign out_ch.out_byte       = head.chars[idx_r];
  assign out_ch.data_valid     = head.dv;
  assign out_ch.end_of_message = head.eom && last_slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (fire) begin
      idx_r <= last_slot ? 2'd0 : idx_r + 2'd1;
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> ({1'b0, idx_r} < head.n))
    else $error("slot index beyond job length");

  a_bare_marker_eom: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.data_valid) |-> out_ch.end_of_message)
    else $error("bare result item without end of message");

endmodule
